FILE: hdl/ilst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared codes and the command beat broadcast along the cell chain.
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int OPCODE_W    = 3;
    localparam int POSITION_W  = 5;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;

    // Wide enough for any cell index or fill count up to the largest capacity
    localparam int CELL_POS_W  = 9;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_ELEMENT_WIDTH = 32;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic                  ins;   // cells at and above pos shift up, pos takes value
        logic                  rem;   // cells at and above pos take their right neighbor
        logic [CELL_POS_W-1:0] pos;   // target cell, also read select
    } cell_cmd_t;

endpackage : ilst_pkg
`default_nettype wire

FILE: hdl/ilst_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilst_cell
// One list entry. Shifts toward or away from its neighbors on insert and
// remove, and offers its value on the read bus when selected.
// ----------------------------------------------------------------------------
module ilst_cell #(
    parameter int IDX           = 0,
    parameter int ELEMENT_WIDTH = ilst_pkg::DEF_ELEMENT_WIDTH
) (
    input  wire                        clk,
    input  wire ilst_pkg::cell_cmd_t   cmd,
    input  wire [ELEMENT_WIDTH-1:0]    wr_value,
    input  wire [ELEMENT_WIDTH-1:0]    left_value,
    input  wire [ELEMENT_WIDTH-1:0]    right_value,
    output logic [ELEMENT_WIDTH-1:0]   value,
    output logic [ELEMENT_WIDTH-1:0]   hit_value
);
    import ilst_pkg::*;

    localparam logic [CELL_POS_W-1:0] MY_IDX = CELL_POS_W'(IDX);

    logic [ELEMENT_WIDTH-1:0] cell_reg;
    logic [ELEMENT_WIDTH-1:0] cell_next;
    logic                     at_pos;
    logic                     above_pos;

    assign at_pos    = (cmd.pos == MY_IDX);
    assign above_pos = (MY_IDX > cmd.pos);

    always_comb
    begin
        cell_next = cell_reg;
        if (cmd.ins)
        begin
            if (at_pos)
                cell_next = wr_value;
            else if (above_pos)
                cell_next = left_value;
        end
        else if (cmd.rem)
        begin
            if (at_pos || above_pos)
                cell_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign value     = cell_reg;
    assign hit_value = cell_reg & {ELEMENT_WIDTH{at_pos}};

endmodule : ilst_cell
`default_nettype wire

FILE: hdl/indexed_array_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_list_top
// Ordered list of up to CAPACITY values held in a row of shifting cells.
//
// Command channel: opcode, position and element_value are taken at a rising
// edge with start high and busy low. busy stays low: a command may be issued
// in every cycle. Opcodes: push tail, pop tail, insert at position, remove
// at position, read at position.
// Result channel: done pulses for one cycle, in the cycle after the command beat,
// with read_value, count, empty_res and status. The receiver cannot stall,
// so results are presented once and never held.
// Throughput is 1 command per cycle: every cell moves to its neighbor's value
// in the same edge, so an insert or remove never holds off the next command,
// whatever the position. The read select is an OR over all cells.
// Reset clears the fill count and the result strobe; cell contents are left
// as they are and are only read below the fill count.
// ----------------------------------------------------------------------------
module indexed_array_list_top #(
    parameter int CAPACITY      = ilst_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = ilst_pkg::DEF_ELEMENT_WIDTH
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [ilst_pkg::OPCODE_W-1:0]         opcode,
    input  wire [ilst_pkg::POSITION_W-1:0]       position,
    input  wire [ELEMENT_WIDTH-1:0]              element_value,
    output logic                                 done,
    output logic [ELEMENT_WIDTH-1:0]             read_value,
    output logic [ilst_pkg::COUNT_W-1:0]         count,
    output logic                                 empty_res,
    output logic [ilst_pkg::STATUS_W-1:0]        status
);
    import ilst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CELL_POS_W-1:0] CAP_VAL = CELL_POS_W'(CAPACITY);

    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      done_reg;
    logic [ELEMENT_WIDTH-1:0]  rd_reg;
    logic [ELEMENT_WIDTH-1:0]  rd_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;

    cell_cmd_t                 cmd;
    logic [CELL_POS_W-1:0]     fill_ext;
    logic [CELL_POS_W-1:0]     pos_ext;
    logic                      accept;
    logic [ELEMENT_WIDTH-1:0]  cell_value [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  cell_hit   [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  hit_or;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign fill_ext = CELL_POS_W'(fill_reg);
    assign pos_ext  = CELL_POS_W'(position);

    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            hit_or = hit_or | cell_hit[i];
    end

    always_comb
    begin
        cmd         = '0;
        cmd.pos     = pos_ext;
        fill_next   = fill_reg;
        rd_next     = '0;
        status_next = ST_OK;
        if (accept)
        begin
            unique case (opcode)
                OP_PUSH:
                begin
                    if (fill_ext == CAP_VAL)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.ins   = 1'b1;
                        cmd.pos   = fill_ext;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (fill_reg == '0)
                        status_next = ST_EMPTY;
                    else
                        fill_next = fill_reg - CNT_W'(1);
                end
                OP_INSERT:
                begin
                    if (fill_ext == CAP_VAL)
                        status_next = ST_FULL;
                    else if (pos_ext > fill_ext)
                        status_next = ST_BADPOS;
                    else
                    begin
                        cmd.ins   = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (pos_ext >= fill_ext)
                        status_next = ST_BADPOS;
                    else
                    begin
                        cmd.rem   = 1'b1;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (pos_ext >= fill_ext)
                        status_next = ST_BADPOS;
                    else
                        rd_next = hit_or;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_v;
        logic [ELEMENT_WIDTH-1:0] right_v;

        if (g == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[g+1];
        end

        ilst_cell #(
            .IDX           (g),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .wr_value    (element_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .hit_value   (cell_hit[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign read_value = rd_reg;
    assign count      = COUNT_W'(fill_reg);
    assign empty_res  = (fill_reg == '0);
    assign status     = status_reg;

    // Every command beat yields a result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after command beat");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_ext <= CAP_VAL)
        else $error("fill count beyond capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (fill_ext == CAP_VAL))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> empty_res)
        else $error("pop-on-empty status with elements held");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> $stable(fill_reg))
        else $error("fill count moved without a command");

endmodule : indexed_array_list_top
`default_nettype wire

FILE: verif/indexed_array_list_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_array_list_top_tb
// Self-checking bench for the indexed array list. A directed table covers
// empty-list errors, spare opcodes, insert at the tail and above it, and
// out-of-range reads and removes. Random sequences then fill the list past
// full, drain it past empty, and mix valid and junk commands, with random
// idle bursts on the command side. Each result beat is compared field by
// field against the typed table row, or else against an in-bench list model.
// ----------------------------------------------------------------------------
module indexed_array_list_top_tb;

    import ilst_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int ELEM_W     = DEF_ELEMENT_WIDTH;
    localparam int NUM_CMDS   = 1150;
    localparam int QUIET_FROM = 1000;     // no idling from here on
    localparam int CYCLE_CAP  = 200000;
    localparam int NUM_DIR    = 25;

    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [ELEM_W-1:0]   rd;
        logic [COUNT_W-1:0]  cnt;
        logic                empty;
        logic [STATUS_W-1:0] st;
    } list_res_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [POSITION_W-1:0] pos;
        logic [ELEM_W-1:0]     val;
        logic                  typed;
        list_res_t             res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [OPCODE_W-1:0]   opcode;
    logic [POSITION_W-1:0] position;
    logic [ELEM_W-1:0]     element_value;
    logic                  done;
    logic [ELEM_W-1:0]     read_value;
    logic [COUNT_W-1:0]    count;
    logic                  empty_res;
    logic [STATUS_W-1:0]   status;

    logic [ELEM_W-1:0] model_cells [CAP];
    int                model_fill;
    list_res_t         pending_results [$];
    int                mismatch_count;
    int                sent_cmds;
    int                cycle_count;
    bit                idle_on;

    indexed_array_list_top #(
        .CAPACITY      (CAP),
        .ELEMENT_WIDTH (ELEM_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .position      (position),
        .element_value (element_value),
        .done          (done),
        .read_value    (read_value),
        .count         (count),
        .empty_res     (empty_res),
        .status        (status)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Directed rows; typed = 1 carries the expected beat, else the model decides
    dir_row_t dir_cmds [NUM_DIR] = '{
        '{OP_POP,     5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_EMPTY}},
        '{OP_REMOVE,  5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_BADPOS}},
        '{OP_READ,    5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_BADPOS}},
        '{OP_INSERT,  5'd1,  32'hDEAD_BEEF, 1'b1, '{32'h0, 5'd0, 1'b1, ST_BADPOS}},
        '{OP_SPARE_A, 5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
        '{OP_SPARE_B, 5'd3,  32'h5555_5555, 1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
        '{OP_SPARE_C, 5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
        '{OP_INSERT,  5'd0,  32'h0,         1'b1, '{32'h0, 5'd1, 1'b0, ST_OK}},
        '{OP_PUSH,    5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd2, 1'b0, ST_OK}},
        '{OP_INSERT,  5'd2,  32'h8000_0001, 1'b1, '{32'h0, 5'd3, 1'b0, ST_OK}},
        '{OP_INSERT,  5'd4,  32'h1111_1111, 1'b1, '{32'h0, 5'd3, 1'b0, ST_BADPOS}},
        '{OP_READ,    5'd1,  32'h0,         1'b1, '{32'hFFFF_FFFF, 5'd3, 1'b0, ST_OK}},
        '{OP_READ,    5'd2,  32'h0,         1'b1, '{32'h8000_0001, 5'd3, 1'b0, ST_OK}},
        '{OP_READ,    5'd3,  32'h0,         1'b1, '{32'h0, 5'd3, 1'b0, ST_BADPOS}},
        '{OP_READ,    5'd31, 32'h0,         1'b1, '{32'h0, 5'd3, 1'b0, ST_BADPOS}},
        '{OP_INSERT,  5'd0,  32'h1234_5678, 1'b0, '0},
        '{OP_READ,    5'd0,  32'h0,         1'b0, '0},
        '{OP_REMOVE,  5'd16, 32'h0,         1'b1, '{32'h0, 5'd4, 1'b0, ST_BADPOS}},
        '{OP_REMOVE,  5'd4,  32'h0,         1'b1, '{32'h0, 5'd4, 1'b0, ST_BADPOS}},
        '{OP_REMOVE,  5'd1,  32'h0,         1'b0, '0},
        '{OP_READ,    5'd1,  32'h0,         1'b0, '0},
        '{OP_POP,     5'd0,  32'h0,         1'b0, '0},
        '{OP_REMOVE,  5'd0,  32'h0,         1'b0, '0},
        '{OP_POP,     5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
        '{OP_POP,     5'd0,  32'h0,         1'b1, '{32'h0, 5'd0, 1'b1, ST_EMPTY}}
    };

    function automatic list_res_t predict_list_op(
        input logic [OPCODE_W-1:0]   op,
        input logic [POSITION_W-1:0] pos,
        input logic [ELEM_W-1:0]     val
    );
        list_res_t r;
        int        p;
        r  = '0;
        p  = int'(pos);
        r.st = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (model_fill >= CAP)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    model_cells[model_fill] = val;
                    model_fill++;
                end
            end
            OP_POP:
            begin
                if (model_fill == 0)
                    r.st = ST_EMPTY;
                else
                    model_fill--;
            end
            OP_INSERT:
            begin
                if (model_fill >= CAP)
                begin
                    r.st = ST_FULL;
                end
                else if (p > model_fill)
                begin
                    r.st = ST_BADPOS;
                end
                else
                begin
                    for (int k = model_fill; k > p; k--)
                        model_cells[k] = model_cells[k-1];
                    model_cells[p] = val;
                    model_fill++;
                end
            end
            OP_REMOVE:
            begin
                if (p >= model_fill)
                begin
                    r.st = ST_BADPOS;
                end
                else
                begin
                    for (int k = p; k + 1 < model_fill; k++)
                        model_cells[k] = model_cells[k+1];
                    model_fill--;
                end
            end
            OP_READ:
            begin
                if (p >= model_fill)
                    r.st = ST_BADPOS;
                else
                    r.rd = model_cells[p];
            end
            default: ;
        endcase
        r.cnt   = COUNT_W'(model_fill);
        r.empty = (model_fill == 0);
        return r;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return ELEM_W'($urandom);
    endfunction

    // Called at a falling edge; drops start and idles for the requested length
    task automatic pause_cmds(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(
        input logic [OPCODE_W-1:0]   op,
        input logic [POSITION_W-1:0] pos,
        input logic [ELEM_W-1:0]     val,
        input bit                    typed,
        input list_res_t             typed_res
    );
        list_res_t predicted;
        if (idle_on && sent_cmds < QUIET_FROM && $urandom_range(0, 2) == 0)
            pause_cmds($urandom_range(1, 11));
        start         <= 1'b1;
        opcode        <= op;
        position      <= pos;
        element_value <= val;
        do @(posedge clk); while (busy);
        predicted = predict_list_op(op, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
        sent_cmds++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        if (pending_results.size() != 0)
        begin
            start <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic send_rand_valid();
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0: send_cmd(OP_PUSH, POSITION_W'($urandom), pick_value(), 1'b0, '0);
            1: send_cmd(OP_POP, POSITION_W'($urandom), pick_value(), 1'b0, '0);
            2: send_cmd(OP_INSERT, POSITION_W'($urandom_range(0, model_fill)),
                        pick_value(), 1'b0, '0);
            3: send_cmd(OP_REMOVE,
                        POSITION_W'(model_fill > 0 ? $urandom_range(0, model_fill - 1) : 0),
                        pick_value(), 1'b0, '0);
            default: send_cmd(OP_READ,
                        POSITION_W'(model_fill > 0 ? $urandom_range(0, model_fill - 1) : 0),
                        pick_value(), 1'b0, '0);
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result beats: done is never held off, so every strobe is a beat
    always @(posedge clk)
    begin
        list_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, read_value %h count %0d status %0d",
                         $time, read_value, count, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_value", want.rd, read_value);
                check_field("count", 32'(want.cnt), 32'(count));
                check_field("empty_res", 32'(want.empty), 32'(empty_res));
                check_field("status", 32'(want.st), 32'(status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  seq_kind;
        int  extra;
        bit  first_seq;
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = OP_PUSH;
        position       = '0;
        element_value  = '0;
        mismatch_count = 0;
        sent_cmds      = 0;
        cycle_count    = 0;
        model_fill     = 0;
        idle_on        = 1'b1;
        first_seq      = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_cmd(dir_cmds[i].op, dir_cmds[i].pos, dir_cmds[i].val,
                     dir_cmds[i].typed, dir_cmds[i].res);
        wait_results_drained();

        while (sent_cmds < NUM_CMDS)
        begin
            seq_kind = first_seq ? 0 : $urandom_range(0, 9);
            first_seq = 1'b0;
            idle_on = ($urandom_range(0, 2) != 0);
            // the closing stretch runs back to back, so no drain there
            if (sent_cmds < QUIET_FROM && $urandom_range(0, 7) == 0)
                wait_results_drained();
            if (seq_kind <= 2)
            begin
                // fill to full, then knock on the full list
                while (model_fill < CAP)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(OP_PUSH, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                    else
                        send_cmd(OP_INSERT, POSITION_W'($urandom_range(0, model_fill)),
                                 pick_value(), 1'b0, '0);
                end
                extra = $urandom_range(1, 3);
                repeat (extra)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(OP_PUSH, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                    else
                        send_cmd(OP_INSERT, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                    send_rand_valid();
                end
            end
            else if (seq_kind <= 4)
            begin
                // drain to empty, then poke the empty list
                while (model_fill > 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(OP_POP, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                    else
                        send_cmd(OP_REMOVE, POSITION_W'($urandom_range(0, model_fill - 1)),
                                 pick_value(), 1'b0, '0);
                    if ($urandom_range(0, 3) == 0)
                        send_rand_valid();
                end
                extra = $urandom_range(1, 3);
                repeat (extra)
                begin
                    case ($urandom_range(0, 3))
                        0: send_cmd(OP_POP, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                        1: send_cmd(OP_REMOVE, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                        2: send_cmd(OP_READ, POSITION_W'($urandom), pick_value(), 1'b0, '0);
                        default: send_cmd(OP_INSERT, POSITION_W'($urandom_range(1, 31)),
                                          pick_value(), 1'b0, '0);
                    endcase
                end
            end
            else if (seq_kind <= 8)
            begin
                extra = $urandom_range(4, 20);
                repeat (extra) send_rand_valid();
            end
            else
            begin
                // junk: any opcode, any position
                extra = $urandom_range(2, 8);
                repeat (extra)
                    send_cmd(OPCODE_W'($urandom), POSITION_W'($urandom), pick_value(),
                             1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : indexed_array_list_top_tb
